// ----- rtl/morse_message_keyer_unit_macros.svh -----
// Assertion macros shared by the Morse keyer RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef MORSE_MESSAGE_KEYER_UNIT_MACROS_SVH
`define MORSE_MESSAGE_KEYER_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MKY_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define MKY_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mky_pkg.sv -----
// Package for the Morse keyer: phase and request codes, register indexes,
// the configuration and result structs, and the unit-time load function.
`default_nettype none

package mky_pkg;

	localparam int DIT_BITS  = 24;
	localparam int TIME_BITS = DIT_BITS + 2;
	localparam int CODE_BITS = 8;
	localparam int SHIFT_BITS = 16;

	typedef logic [DIT_BITS-1:0]   dit_t;
	typedef logic [TIME_BITS-1:0]  time_t;
	typedef logic [CODE_BITS-1:0]  code_t;

	// Reset value of the unit length: 1200/13 ms rounded down.
	localparam dit_t DIT_RESET = dit_t'(1200 / 13);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LEAD  = 3'd1,
		PH_READY = 3'd2,
		PH_ELEM  = 3'd3,
		PH_EGAP  = 3'd4,
		PH_CGAP  = 3'd5,
		PH_WGAP  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_START  = 2'd1,
		REQ_SYMBOL = 2'd2,
		REQ_END    = 2'd3
	} req_t;

	localparam logic [1:0] CFG_DIT_MS    = 2'd0;
	localparam logic [1:0] CFG_QRSS_MODE = 2'd1;
	localparam logic [1:0] CFG_SHIFT_HZ  = 2'd2;

	// Lengths of the timed phases in dit units.
	localparam logic [2:0] UNITS_DIT   = 3'd1;
	localparam logic [2:0] UNITS_CHAR  = 3'd2;
	localparam logic [2:0] UNITS_DAH   = 3'd3;
	localparam logic [2:0] UNITS_WORD  = 3'd4;

	typedef struct packed {
		dit_t                   dit_ms;
		logic                   qrss_mode;
		logic signed [SHIFT_BITS-1:0] shift_hz;
	} cfg_t;

	typedef struct packed {
		logic                   aborted;
		logic                   ready_res;
		logic                   busy_res;
		logic signed [SHIFT_BITS-1:0] freq_offset;
		logic                   sidetone_on;
	} result_t;

	// Unit count times the dit length, built from shifts and one add.
	function automatic time_t unit_time(input dit_t dit, input logic [2:0] units);
		time_t one;
		time_t two;
		time_t res;
		one = {2'b00, dit};
		two = {1'b0, dit, 1'b0};
		case (units)
			UNITS_DIT:  res = one;
			UNITS_CHAR: res = two;
			UNITS_DAH:  res = one + two;
			UNITS_WORD: res = {dit, 2'b00};
			default:    res = '0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/mky_cfg_regs.sv -----
// Configuration register file of the Morse keyer: unit length, mode, shift.
// Depends on mky_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module mky_cfg_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [1:0]                cfg_addr,
	input  wire logic [mky_pkg::DIT_BITS-1:0] cfg_data,
	output mky_pkg::cfg_t                  cfg
);
	import mky_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dit_ms    <= DIT_RESET;
			cfg_q.qrss_mode <= 1'b0;
			cfg_q.shift_hz  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_DIT_MS:    cfg_q.dit_ms    <= cfg_data;
				CFG_QRSS_MODE: cfg_q.qrss_mode <= cfg_data[0];
				CFG_SHIFT_HZ:  cfg_q.shift_hz  <= cfg_data[SHIFT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/mky_core.sv -----
// Keyer state and its combinational update for one accepted transaction.
// Depends on mky_pkg; assertions use morse_message_keyer_unit_macros.svh.
`default_nettype none
`include "morse_message_keyer_unit_macros.svh"

module mky_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               acc,
	input  wire logic [1:0]         req_type,
	input  wire logic [mky_pkg::CODE_BITS-1:0] code_pattern,
	input  wire logic               is_space,
	input  wire logic               key_closed,
	input  wire mky_pkg::cfg_t      cfg,
	output mky_pkg::result_t        res
);
	import mky_pkg::*;

	phase_t phase_q, phase_d;
	code_t  code_shift_q, code_shift_d;
	time_t  time_left_q, time_left_d;
	logic   tone_q, tone_d;
	logic   abort_d;
	logic   load_en;
	logic [2:0] load_units;
	code_t  shifted;
	req_t   req;
	logic   sounding;

	assign req     = req_t'(req_type);
	assign shifted = code_shift_q >> 1;

	// Next-state logic. A timed phase that is loaded picks its unit count
	// here, and the single shared multiply-by-units runs afterwards.
	always_comb begin
		phase_d      = phase_q;
		code_shift_d = code_shift_q;
		time_left_d  = time_left_q;
		tone_d       = tone_q;
		abort_d      = 1'b0;
		load_en      = 1'b0;
		load_units   = UNITS_DIT;
		case (req)
			REQ_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (key_closed) begin
						phase_d      = PH_IDLE;
						code_shift_d = '0;
						time_left_d  = '0;
						tone_d       = 1'b0;
						abort_d      = 1'b1;
					end else if (phase_q != PH_READY) begin
						if (time_left_q > time_t'(1)) begin
							time_left_d = time_left_q - time_t'(1);
						end else begin
							case (phase_q)
								PH_LEAD, PH_CGAP, PH_WGAP: begin
									phase_d     = PH_READY;
									time_left_d = '0;
								end
								PH_ELEM: begin
									phase_d    = PH_EGAP;
									load_en    = 1'b1;
									load_units = UNITS_DIT;
								end
								PH_EGAP: begin
									code_shift_d = shifted;
									load_en      = 1'b1;
									if (shifted > code_t'(1)) begin
										phase_d    = PH_ELEM;
										load_units = shifted[0] ? UNITS_DIT : UNITS_DAH;
									end else begin
										phase_d    = PH_CGAP;
										load_units = UNITS_CHAR;
									end
								end
								default: ;
							endcase
						end
					end
				end
			end
			REQ_START: begin
				if (key_closed) begin
					phase_d      = PH_IDLE;
					code_shift_d = '0;
					time_left_d  = '0;
					tone_d       = 1'b0;
					abort_d      = 1'b1;
				end else begin
					phase_d      = PH_LEAD;
					code_shift_d = '0;
					load_en      = 1'b1;
					load_units   = UNITS_DIT;
					tone_d       = cfg.qrss_mode;
				end
			end
			REQ_SYMBOL: begin
				if (phase_q == PH_READY) begin
					load_en = 1'b1;
					if (is_space) begin
						phase_d    = PH_WGAP;
						load_units = UNITS_WORD;
					end else begin
						code_shift_d = code_pattern;
						if (code_pattern > code_t'(1)) begin
							phase_d    = PH_ELEM;
							load_units = code_pattern[0] ? UNITS_DIT : UNITS_DAH;
						end else begin
							phase_d    = PH_CGAP;
							load_units = UNITS_CHAR;
						end
					end
				end
			end
			default: begin
				phase_d      = PH_IDLE;
				code_shift_d = '0;
				time_left_d  = '0;
				tone_d       = 1'b0;
			end
		endcase
		if (load_en) begin
			time_left_d = unit_time(cfg.dit_ms, load_units);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			code_shift_q <= '0;
			time_left_q  <= '0;
			tone_q       <= 1'b0;
		end else if (acc) begin
			phase_q      <= phase_d;
			code_shift_q <= code_shift_d;
			time_left_q  <= time_left_d;
			tone_q       <= tone_d;
		end
	end

	// Result seen after the update; the output stage registers it.
	assign sounding        = (phase_d == PH_ELEM);
	assign res.sidetone_on = tone_d | (sounding & ~cfg.qrss_mode);
	assign res.freq_offset = (sounding && cfg.qrss_mode) ? cfg.shift_hz : '0;
	assign res.busy_res    = (phase_d != PH_IDLE) && (phase_d != PH_READY);
	assign res.ready_res   = (phase_d == PH_READY);
	assign res.aborted     = abort_d;

	`MKY_ASSERT(a_elem_has_code, !(phase_q == PH_ELEM || phase_q == PH_EGAP) || (code_shift_q > code_t'(1)), "element phase without remaining code bits")
	`MKY_ASSERT(a_idle_ready_no_time, !(phase_q == PH_IDLE || phase_q == PH_READY) || (time_left_q == '0), "timer running while idle or ready")
	`MKY_ASSERT(a_idle_clear, (phase_q != PH_IDLE) || (!tone_q && code_shift_q == '0), "idle with tone latch or code left over")
	`MKY_ASSERT_NEXT(a_end_idles, acc && req == REQ_END, phase_q == PH_IDLE, "end transaction did not return to idle")

endmodule

`default_nettype wire

// ----- rtl/mky_out_stage.sv -----
// Result register of the Morse keyer with its valid flag and stream handshake.
// Depends on mky_pkg for the result_t struct.
`default_nettype none

module mky_out_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire mky_pkg::result_t res,
	input  wire logic          out_ready,
	output wire logic          out_valid,
	output wire logic          can_load,
	output mky_pkg::result_t   res_out
);
	import mky_pkg::*;

	result_t res_q;
	logic    valid_q;

	// The register frees up in the same cycle that its content is taken.
	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

`default_nettype wire

// ----- rtl/morse_message_keyer_unit.sv -----
// Top level of the Morse message keyer: stream ports, config port, wiring.
// Depends on mky_pkg, mky_cfg_regs, mky_core and mky_out_stage.
//
//   Channel   Direction  Payload                                   Handshake
//   s_axis    in         tuser: req_type; tdata: code, flags       tvalid/tready
//   m_axis    out        tdata: tone, offset, busy, ready, abort   tvalid/tready
//   cfg       in         cfg_addr selects, cfg_data written        cfg_wr_en
//
// Every input transaction yields exactly one result transaction, registered
// when it is accepted. The keyer state is updated in the accepting cycle by
// a single combinational pass, so a new item can be taken every clock; the
// result register sets the rate, and s_axis_tready is low only while a result
// is held and m_axis_tready is low. Reset is asynchronous and active low; it
// returns the keyer to idle and loads the register defaults (unit 92 ms).
`default_nettype none

module morse_message_keyer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// tdata: code_pattern[7:0], is_space[8], key_closed[9], zero[15:10]
	input  wire logic [15:0] s_axis_tdata,
	// tuser: req_type[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        s_axis_tvalid,
	output wire logic        s_axis_tready,
	// tdata: sidetone_on[0], freq_offset[16:1], busy_res[17], ready_res[18],
	//        aborted[19], zero[23:20]
	output wire logic [23:0] m_axis_tdata,
	output wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [mky_pkg::DIT_BITS-1:0] cfg_data
);
	import mky_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_out;
	logic    acc;
	logic    can_load;

	// A transaction is taken whenever the result register is free or is
	// being emptied in the same cycle.
	assign s_axis_tready = can_load;
	assign acc           = s_axis_tvalid && can_load;

	mky_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mky_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.req_type     (s_axis_tuser),
		.code_pattern (s_axis_tdata[7:0]),
		.is_space     (s_axis_tdata[8]),
		.key_closed   (s_axis_tdata[9]),
		.cfg          (cfg),
		.res          (res)
	);

	mky_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (acc),
		.res       (res),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.can_load  (can_load),
		.res_out   (res_out)
	);

	// The result struct is declared in the same bit order as the tdata map.
	assign m_axis_tdata = {4'b0000, res_out};

endmodule

`default_nettype wire

// ----- bench/morse_message_keyer_unit_test.sv -----
// Self-checking testbench for the Morse message keyer: stream stimulus,
// an in-bench prediction of the keyer, and a scoreboard of expected results.
// Depends on mky_pkg and morse_message_keyer_unit; needs nothing else.
`default_nettype none

module morse_message_keyer_unit_test;

	import mky_pkg::*;

	// Cycles in which no transaction moves on either stream before the run
	// is called hung. The slowest legal stretch is a receiver stall plus the
	// register writes of one setting, so this is far beyond it.
	localparam int QUIET_LIMIT = 2000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic [15:0]       s_axis_tdata;
	logic [1:0]        s_axis_tuser;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [23:0]       m_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic              cfg_wr_en;
	logic [1:0]        cfg_addr;
	logic [DIT_BITS-1:0] cfg_data;

	morse_message_keyer_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bench copy of the keyer registers, updated as each write lands.
	dit_t                    unit_ms;
	logic                    qrss_on;
	logic signed [15:0]      shift_offset;

	// Bench copy of the keyer state.
	phase_t                  key_phase;
	code_t                   code_left;
	time_t                   ticks_left;
	logic                    tone_latch;
	logic                    item_ignored;

	result_t                 expected_results[$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_count;
	int items_sent;
	int useful_items;
	int symbols_given;
	int aborts_seen;
	int settings_applied;
	int results_checked;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic time_t unit_ticks(logic [2:0] units);
		time_t base;
		base = {2'b00, unit_ms};
		return base * time_t'(units);
	endfunction

	function automatic void clear_keyer();
		key_phase  = PH_IDLE;
		code_left  = '0;
		ticks_left = '0;
		tone_latch = 1'b0;
	endfunction

	// The lowest remaining code bit picks a dit or a dah.
	function automatic void begin_element();
		key_phase  = PH_ELEM;
		ticks_left = unit_ticks(code_left[0] ? UNITS_DIT : UNITS_DAH);
	endfunction

	// Applies one accepted input transaction to the bench state and returns
	// the result the keyer must send for it.
	function automatic result_t predict_keyer(req_t req, code_t code, logic space, logic key);
		result_t r;
		logic    abort_now;
		logic    sounding;
		abort_now    = 1'b0;
		item_ignored = 1'b0;
		case (req)
			REQ_TICK: begin
				if (key_phase == PH_IDLE) begin
					item_ignored = 1'b1;
				end else if (key) begin
					clear_keyer();
					abort_now = 1'b1;
				end else if (key_phase == PH_READY) begin
					item_ignored = 1'b1;
				end else if (ticks_left > 1) begin
					ticks_left = ticks_left - 1'b1;
				end else begin
					// The running timed phase has ended on this tick.
					case (key_phase)
						PH_ELEM: begin
							key_phase  = PH_EGAP;
							ticks_left = unit_ticks(UNITS_DIT);
						end
						PH_EGAP: begin
							code_left = code_left >> 1;
							if (code_left > 1) begin
								begin_element();
							end else begin
								key_phase  = PH_CGAP;
								ticks_left = unit_ticks(UNITS_CHAR);
							end
						end
						default: begin
							key_phase  = PH_READY;
							ticks_left = '0;
						end
					endcase
				end
			end
			REQ_START: begin
				if (key) begin
					clear_keyer();
					abort_now = 1'b1;
				end else begin
					key_phase  = PH_LEAD;
					code_left  = '0;
					ticks_left = unit_ticks(UNITS_DIT);
					tone_latch = qrss_on;
				end
			end
			REQ_SYMBOL: begin
				if (key_phase != PH_READY) begin
					item_ignored = 1'b1;
				end else if (space) begin
					key_phase  = PH_WGAP;
					ticks_left = unit_ticks(UNITS_WORD);
				end else begin
					code_left = code;
					if (code > 1) begin
						begin_element();
					end else begin
						// Nothing above the sentinel: straight to the character gap.
						key_phase  = PH_CGAP;
						ticks_left = unit_ticks(UNITS_CHAR);
					end
				end
			end
			default: begin
				clear_keyer();
			end
		endcase
		sounding      = (key_phase == PH_ELEM);
		r.sidetone_on = tone_latch | (sounding & ~qrss_on);
		r.freq_offset = (sounding && qrss_on) ? shift_offset : 16'sd0;
		r.busy_res    = (key_phase != PH_IDLE) && (key_phase != PH_READY);
		r.ready_res   = (key_phase == PH_READY);
		r.aborted     = abort_now;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Offers one item on the input stream, holding it until the keyer takes
	// it. Returns just after the accepting edge, with valid still high so
	// that back-to-back items need no second assignment in one step.
	task automatic send_item(req_t req, code_t code, logic space, logic key);
		result_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {6'b0, key, space, code};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		want = predict_keyer(req, code, space, key);
		expected_results.push_back(want);
		items_sent++;
		if (!item_ignored)
			useful_items++;
		if (want.aborted)
			aborts_seen++;
	endtask

	task automatic send_tick(logic key);
		send_item(REQ_TICK, code_t'($urandom), 1'($urandom_range(1)), key);
	endtask

	// Stops offering items and waits until every result is back, then lets the
	// last transfer settle so that the keyer is left quiet.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Writes all three registers in a row while no transaction is in flight.
	// The unused upper data bits carry noise on the narrow registers.
	task automatic set_keyer_config(dit_t dit, logic qrss, logic signed [15:0] shift);
		logic [DIT_BITS-1:0] word;
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_addr  <= CFG_DIT_MS;
		cfg_data  <= dit;
		@(posedge clk);
		unit_ms = dit;
		word    = DIT_BITS'($urandom);
		word[0] = qrss;
		cfg_addr <= CFG_QRSS_MODE;
		cfg_data <= word;
		@(posedge clk);
		qrss_on = qrss;
		word       = DIT_BITS'($urandom);
		word[15:0] = shift;
		cfg_addr <= CFG_SHIFT_HZ;
		cfg_data <= word;
		@(posedge clk);
		shift_offset = shift;
		cfg_wr_en <= 1'b0;
		settings_applied++;
	endtask

	task automatic tick_until_ready();
		while (key_phase != PH_READY && key_phase != PH_IDLE)
			send_tick(1'b0);
	endtask

	// Mostly short characters; now and then a fully random byte, which
	// also brings in the empty patterns 0 and 1.
	function automatic code_t random_code();
		int len;
		len = $urandom_range(7);
		if ($urandom_range(9) == 0)
			return code_t'($urandom);
		return code_t'((1 << len) | ($urandom & ((1 << len) - 1)));
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Sampled on the falling edge: a result seen here with ready high is
	// the one transferred on the next rising edge.
	always @(negedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[19:0]);
			results_checked++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %h arrived with nothing expected",
					m_axis_tdata));
			end else begin
				want = expected_results.pop_front();
				if (got.sidetone_on !== want.sidetone_on)
					report_mismatch($sformatf("sidetone_on %b, expected %b",
						got.sidetone_on, want.sidetone_on));
				if (got.freq_offset !== want.freq_offset)
					report_mismatch($sformatf("freq_offset %0d, expected %0d",
						got.freq_offset, want.freq_offset));
				if (got.busy_res !== want.busy_res)
					report_mismatch($sformatf("busy_res %b, expected %b",
						got.busy_res, want.busy_res));
				if (got.ready_res !== want.ready_res)
					report_mismatch($sformatf("ready_res %b, expected %b",
						got.ready_res, want.ready_res));
				if (got.aborted !== want.aborted)
					report_mismatch($sformatf("aborted %b, expected %b",
						got.aborted, want.aborted));
			end
		end
	end

	// The receiver drops ready at random; one assignment per edge.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Hang detector: counts cycles in which neither stream moves a
	// transaction and gives up once the count reaches the limit.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Out of reset the unit is 92 ticks in CW mode. A tick or a closed key
	// in idle, and a symbol during the lead pause, must all be ignored,
	// apart from the abort flag that a keyed start raises.
	task automatic test_reset_defaults();
		send_item(REQ_TICK, 8'hFF, 1'b1, 1'b1);
		send_item(REQ_START, 8'h00, 1'b0, 1'b1);
		send_item(REQ_START, 8'h00, 1'b0, 1'b0);
		send_item(REQ_SYMBOL, 8'h03, 1'b0, 1'b0);
		repeat (3) send_tick(1'b0);
		send_item(REQ_END, 8'h00, 1'b0, 1'b0);
	endtask

	// One-tick unit in CW mode: a dah-dit character with the key flag set
	// (ignored on symbols), a symbol offered mid-element, both empty
	// patterns, and a word space whose pattern bits are all set.
	task automatic test_cw_keying();
		set_keyer_config(24'd1, 1'b0, 16'sh7FFF);
		send_item(REQ_START, 8'h00, 1'b0, 1'b0);
		tick_until_ready();
		send_item(REQ_SYMBOL, 8'b0000_0110, 1'b0, 1'b1);
		send_item(REQ_SYMBOL, 8'h03, 1'b0, 1'b0);
		tick_until_ready();
		send_item(REQ_SYMBOL, 8'h00, 1'b0, 1'b0);
		tick_until_ready();
		send_item(REQ_SYMBOL, 8'h01, 1'b0, 1'b0);
		tick_until_ready();
		send_item(REQ_SYMBOL, 8'hFF, 1'b1, 1'b0);
		tick_until_ready();
		send_item(REQ_END, 8'h00, 1'b0, 1'b1);
	endtask

	// A zero unit still lasts one tick. QRSS latches the tone at the start
	// and shifts the frequency during elements; the mode is switched while
	// the character is running, and a keyed tick then aborts it.
	task automatic test_qrss_shift();
		set_keyer_config(24'd0, 1'b1, -16'sd32768);
		send_item(REQ_START, 8'h00, 1'b0, 1'b0);
		tick_until_ready();
		send_item(REQ_SYMBOL, 8'hFF, 1'b0, 1'b0);
		repeat (4) send_tick(1'b0);
		set_keyer_config(24'd0, 1'b0, 16'sh7FFF);
		repeat (4) send_tick(1'b0);
		set_keyer_config(24'd0, 1'b1, 16'sh1234);
		repeat (3) send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
	endtask

	// A start while a message is open restarts the lead pause; an end cuts
	// a dah short; an end and a symbol in idle change nothing.
	task automatic test_restart_and_end();
		set_keyer_config(24'd2, 1'b1, -16'sd1);
		send_item(REQ_START, 8'h00, 1'b0, 1'b0);
		tick_until_ready();
		send_item(REQ_START, 8'h00, 1'b0, 1'b0);
		tick_until_ready();
		send_item(REQ_SYMBOL, 8'h02, 1'b0, 1'b0);
		repeat (2) send_tick(1'b0);
		send_item(REQ_END, 8'h55, 1'b1, 1'b0);
		send_item(REQ_END, 8'hAA, 1'b0, 1'b1);
		send_item(REQ_SYMBOL, 8'h06, 1'b0, 1'b0);
	endtask

	// The longest unit: the lead pause cannot end within a few ticks.
	task automatic test_longest_unit();
		set_keyer_config(24'hFF_FFFF, 1'b0, 16'sd0);
		send_item(REQ_START, 8'h00, 1'b0, 1'b0);
		send_item(REQ_SYMBOL, 8'h03, 1'b0, 1'b0);
		repeat (4) send_tick(1'b0);
		send_item(REQ_END, 8'h00, 1'b0, 1'b0);
	endtask

	// Ticks the running phase down, mixing in rare keyed aborts, restarts,
	// ends and symbols offered while the keyer is still busy.
	task automatic advance_with_noise();
		int pick;
		while (key_phase != PH_READY && key_phase != PH_IDLE) begin
			pick = $urandom_range(999);
			if (pick < 5)
				send_tick(1'b1);
			else if (pick < 25)
				send_item(REQ_SYMBOL, random_code(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			else if (pick < 28)
				send_item(REQ_START, code_t'($urandom), 1'($urandom_range(1)), 1'b0);
			else if (pick < 30)
				send_item(REQ_END, code_t'($urandom), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			else
				send_tick(1'b0);
		end
	endtask

	// One well-formed message with random content under a fresh setting.
	task automatic keyer_random_message();
		int   pick;
		int   n_sym;
		dit_t dit;
		pick = $urandom_range(99);
		dit  = (pick < 25) ? 24'd0 : (pick < 65) ? 24'd1 : dit_t'($urandom_range(3, 2));
		set_keyer_config(dit, 1'($urandom_range(1)), 16'($urandom));
		n_sym = $urandom_range(6, 1);
		send_item(REQ_START, code_t'($urandom), 1'($urandom_range(1)),
			($urandom_range(99) < 4));
		for (int i = 0; i < n_sym; i++) begin
			advance_with_noise();
			if (key_phase == PH_IDLE)
				return;
			pick = $urandom_range(99);
			if (pick < 4)
				set_keyer_config(unit_ms, 1'($urandom_range(1)), 16'($urandom));
			else if (pick >= 95)
				send_tick(1'b0);
			send_item(REQ_SYMBOL, random_code(), ($urandom_range(99) < 15),
				1'($urandom_range(1)));
			symbols_given++;
		end
		if ($urandom_range(9) != 0)
			advance_with_noise();
		if (key_phase != PH_IDLE)
			send_item(REQ_END, code_t'($urandom), 1'($urandom_range(1)),
				1'($urandom_range(1)));
	endtask

	task automatic test_random_messages(int send_pct, int recv_pct, int quota);
		int target;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = items_sent + quota;
		while (items_sent < target)
			keyer_random_message();
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= REQ_TICK;
		m_axis_tready <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_addr      <= CFG_DIT_MS;
		cfg_data      <= '0;
		unit_ms       = DIT_RESET;
		qrss_on       = 1'b0;
		shift_offset  = 16'sd0;
		clear_keyer();
		send_idle_pct = 34;
		recv_idle_pct = 64;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_cw_keying();
		test_qrss_shift();
		test_restart_and_end();
		test_longest_unit();
		test_random_messages(34, 64, 250);
		test_random_messages(64, 34, 250);
		test_random_messages(0, 0, 250);

		drain_results();
		repeat (4) @(posedge clk);
		$display("Run covered %0d input transactions (%0d changed state), %0d symbols keyed,",
			items_sent, useful_items, symbols_given);
		$display("%0d aborts by key closure, %0d register settings and %0d checked results.",
			aborts_seen, settings_applied, results_checked);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
